[rtl/core/bboa_pkg.sv]
`default_nettype none
package bboa_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_POW = 4'd5,
        OP_GT  = 4'd6,
        OP_LT  = 4'd7,
        OP_GE  = 4'd8,
        OP_LE  = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POW_RANGE = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_DIV_OVF   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_POW_SQ,
        S_POW_MUL,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/core/basic_binary_op_alu_core.sv]
// Channel   Signals                                      Handshake
// command   start, op, first_operand, second_operand     start & !busy
// result    done, result_value, status                   done, one cycle
//
// Add, subtract, compare, equality: done and the result are registered directly on accept.
// Multiply: one shift-add step per cycle over DATA_WIDTH steps.
// Divide: one restoring step per cycle over DATA_WIDTH steps.
// Power: each exponent step runs one setup state (S_POW_SQ), then one shift-add
//   step per bit of |base|, stopping at the first overflow (base magnitude 2
//   is the longest case).
// Reset clears the sequencer; busy is high from accept until done.
// The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none
module basic_binary_op_alu_core
#(
    parameter int DATA_WIDTH = bboa_pkg::DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [3:0]            op,
    input  wire logic [DATA_WIDTH-1:0] first_operand,
    input  wire logic [DATA_WIDTH-1:0] second_operand,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result_value,
    output logic [1:0]                 status
);
    import bboa_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    state_t          state_reg, state_next;
    logic [W-1:0]    a_reg, a_next;       // multiplier / divisor magnitude / pow base magnitude
    logic [W-1:0]    b_reg, b_next;       // base or dividend magnitude
    logic [W-1:0]    acc_reg, acc_next;   // product / quotient
    logic [W:0]      rem_reg, rem_next;   // remainder or multiply accumulator
    logic [W-1:0]    mc_reg, mc_next;     // multiplicand shift
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic            flag_reg, flag_next; // pow: acc_neg of result
    logic [W-1:0]    res_reg, res_next;
    status_t         st_reg, st_next;
    logic            done_reg, done_next;
    logic [W-1:0]    e_reg, e_next;       // pow exponent remaining
    logic            ovf_reg, ovf_next;   // pow multiply overflow
    logic [W-1:0]    plim_reg, plim_next; // pow product limit

    logic signed [W-1:0] sa, sb;
    logic [W-1:0]    mag_a, mag_b, min_v;
    logic [W:0]      trial;

    function automatic logic a_next_nz(input logic [W-1:0] v);
        return (v >> 1) != '0;
    endfunction

    assign sa    = signed'(first_operand);
    assign sb    = signed'(second_operand);
    assign mag_a = first_operand[W-1]  ? W'(-first_operand)  : first_operand;
    assign mag_b = second_operand[W-1] ? W'(-second_operand) : second_operand;
    assign min_v = {1'b1, {(W-1){1'b0}}};
    assign trial = {rem_reg[W-1:0], b_reg[W-1]} - {1'b0, a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        mc_reg   <= mc_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        flag_reg <= flag_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        e_reg    <= e_next;
        ovf_reg  <= ovf_next;
        plim_reg <= plim_next;
    end

    // Power: acc_reg holds |acc|; each exponent unit multiplies |acc| by
    // |base| with a shift-add over at most W steps, tracking overflow against plim.
    always_comb
    begin
        logic [W:0] sum;
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        mc_next    = mc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        flag_next  = flag_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        e_next     = e_reg;
        ovf_next   = ovf_reg;
        plim_next  = plim_reg;
        done_next  = 1'b0;
        sum        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next    = ST_OK;
                    res_next   = '0;
                    state_next = S_DONE;
                    done_next  = 1'b1;
                    case (op)
                        OP_ADD: res_next = second_operand + first_operand;
                        OP_SUB: res_next = second_operand - first_operand;
                        OP_EQ:  res_next = W'(sa == sb);
                        OP_GT:  res_next = W'(sb > sa);
                        OP_LT:  res_next = W'(sb < sa);
                        OP_GE:  res_next = W'(sb >= sa);
                        OP_LE:  res_next = W'(sb <= sa);
                        OP_MUL:
                        begin
                            a_next     = first_operand;
                            mc_next    = second_operand;
                            acc_next   = '0;
                            cnt_next   = CW'(W);
                            done_next  = 1'b0;
                            state_next = S_MUL;
                        end
                        OP_DIV:
                        begin
                            if (first_operand == '0)
                                st_next = ST_DIV_ZERO;
                            else if (first_operand == '1 && second_operand == min_v)
                                st_next = ST_DIV_OVF;
                            else
                            begin
                                a_next     = mag_a;
                                b_next     = mag_b;
                                rem_next   = '0;
                                acc_next   = '0;
                                neg_next   = first_operand[W-1] ^ second_operand[W-1];
                                cnt_next   = CW'(W);
                                done_next  = 1'b0;
                                state_next = S_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (sa <= 0 || second_operand == W'(1))
                                res_next = W'(1);
                            else if (second_operand == '0)
                                res_next = '0;
                            else if (second_operand == '1)
                                res_next = first_operand[0] ? '1 : W'(1);
                            else
                            begin
                                b_next     = mag_b;
                                neg_next   = second_operand[W-1];
                                e_next     = first_operand;
                                acc_next   = W'(1);
                                flag_next  = 1'b0;
                                done_next  = 1'b0;
                                state_next = S_POW_SQ;
                            end
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            S_MUL:
            begin
                if (a_reg[0])
                    acc_next = acc_reg + mc_reg;
                a_next   = a_reg >> 1;
                mc_next  = mc_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    res_next   = a_reg[0] ? acc_reg + mc_reg : acc_reg;
                    done_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (!trial[W])
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-1:0], b_reg[W-1]};
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    res_next   = neg_reg ? W'(-acc_next) : acc_next;
                    done_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_POW_SQ:
            begin
                // Start one multiply step |acc| * |base|.
                flag_next  = flag_reg ^ neg_reg;
                plim_next  = (flag_reg ^ neg_reg) ? min_v : (min_v - 1'b1);
                a_next     = b_reg;
                mc_next    = acc_reg;
                rem_next   = '0;
                ovf_next   = 1'b0;
                cnt_next   = CW'(W);
                state_next = S_POW_MUL;
            end
            S_POW_MUL:
            begin
                sum = rem_reg;
                if (a_reg[0])
                begin
                    sum = rem_reg + {1'b0, mc_reg};
                end
                if (sum > {1'b0, plim_reg} || (a_next_nz(a_reg) && mc_reg[W-1]))
                    ovf_next = 1'b1;
                rem_next = sum;
                if (sum > {1'b0, plim_reg})
                    rem_next = {1'b0, plim_reg};
                a_next   = a_reg >> 1;
                mc_next  = mc_reg[W-1] ? mc_reg : mc_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1) || (a_reg >> 1) == '0)
                begin
                    if (ovf_next)
                    begin
                        st_next    = ST_POW_RANGE;
                        res_next   = '0;
                        done_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (e_reg == W'(1))
                    begin
                        res_next   = flag_reg ? W'(-rem_next[W-1:0]) : rem_next[W-1:0];
                        done_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = rem_next[W-1:0];
                        e_next     = e_reg - 1'b1;
                        state_next = S_POW_SQ;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign status       = st_reg;

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a transaction");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> result_value == '0)
        else $error("nonzero result with error status");

endmodule
`default_nettype wire
